@@ design/euclidean_distance_stream_assert.svh @@
// Assertion macros for the euclidean distance stream block.
`ifndef EUCLIDEAN_DISTANCE_STREAM_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_STREAM_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while in reset
`define EDS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("euclidean_distance_stream: check failed");
// Next-cycle implication, sampled on clk, off while in reset
`define EDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("euclidean_distance_stream: check failed");
`else
`define EDS_ASSERT_IMPL(label, ante, cons)
`define EDS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/eds_pkg.sv @@
// Shared types and constants for the euclidean distance stream block.
`default_nettype none

package eds_pkg;

    // Width and ceiling of the distance result field
    localparam int          DIST_W   = 24;
    localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;

    // Control tag that travels with each root computation down the cell row
    typedef struct packed {
        logic valid;
        logic ovf;
    } eds_tag_t;

endpackage

`default_nettype wire

@@ design/euclidean_distance_stream.sv @@
// Top level: squared-difference accumulator feeding a row of square root cells.
// Pipeline: after the last pair is accepted, a result passes the difference, square
//   and accumulate registers, then one cell per root bit.
// Throughput: one pair per cycle while no result is stalled; the root of one vector runs
//   in the cell row while the next vector accumulates. A stalled result holds every stage.
// Reset: rst_n clears all valid flags, the running sum and the overflow flag.
`default_nettype none
`include "euclidean_distance_stream_assert.svh"

module euclidean_distance_stream
    import eds_pkg::*;
#(
    parameter int ELEM_WIDTH = 16,
    parameter int SUM_WIDTH  = 48
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // elem_a, elem_b, zero fill to whole bytes
    input  wire logic [((2*ELEM_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tlast,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // distance
    output logic [DIST_W-1:0]                          m_tdata,
    // sum_overflow
    output logic [0:0]                                 m_tuser
);

    localparam int EW     = ELEM_WIDTH;
    localparam int SQ_W   = 2 * EW;
    localparam int ACC_W  = ((SQ_W > SUM_WIDTH) ? SQ_W : SUM_WIDTH) + 1;
    localparam int ROOT_W = (SUM_WIDTH + 1) / 2;
    localparam int X_W    = 2 * ROOT_W;
    localparam int QX_W   = ROOT_W + DIST_W;
    localparam logic [SUM_WIDTH-1:0] SUM_ALL = {SUM_WIDTH{1'b1}};
    localparam logic [ACC_W-1:0]     SUM_MAX = ACC_W'(SUM_ALL);

    logic advance;
    logic in_accept;

    // Difference stage
    logic [EW-1:0] elem_a;
    logic [EW-1:0] elem_b;
    logic [EW:0]   diff;
    logic [EW:0]   diff_neg;
    logic [EW:0]   mag_full;
    logic          a_valid_reg;
    logic          a_last_reg;
    logic [EW-1:0] a_mag_reg;

    // Square stage
    logic [SQ_W-1:0] sq_next;
    logic            b_valid_reg;
    logic            b_last_reg;
    logic [SQ_W-1:0] b_sq_reg;

    // Accumulate stage
    logic [ACC_W-1:0]     sum_ext;
    logic                 sat;
    logic [SUM_WIDTH-1:0] sum_next;
    logic                 ovf_next;
    logic [SUM_WIDTH-1:0] sum_reg;
    logic                 ovf_reg;
    eds_tag_t             h_tag_reg;
    logic [SUM_WIDTH-1:0] h_sum_reg;

    // Cell row
    eds_tag_t          tag_chain [ROOT_W+1];
    logic [X_W-1:0]    x_chain   [ROOT_W];
    logic [ROOT_W:0]   rem_chain [ROOT_W];
    logic [ROOT_W-1:0] q_chain   [ROOT_W+1];

    // Output saturation
    logic [QX_W-1:0] q_wide;

    // Whole pipe moves unless a finished result is held up
    assign advance   = !tag_chain[ROOT_W].valid || m_tready;
    assign s_tready  = advance;
    assign in_accept = s_tvalid && advance;

    // Magnitude of the difference; fits EW bits
    assign elem_a   = s_tdata[EW-1:0];
    assign elem_b   = s_tdata[2*EW-1:EW];
    assign diff     = {elem_a[EW-1], elem_a} - {elem_b[EW-1], elem_b};
    assign diff_neg = ~diff + 1'b1;
    assign mag_full = diff[EW] ? diff_neg : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_last_reg <= s_tlast;
            a_mag_reg  <= mag_full[EW-1:0];
            b_last_reg <= a_last_reg;
            b_sq_reg   <= sq_next;
        end
    end

    assign sq_next = SQ_W'(a_mag_reg) * SQ_W'(a_mag_reg);

    // Saturating add into the running sum
    assign sum_ext  = ACC_W'(sum_reg) + ACC_W'(b_sq_reg);
    assign sat      = (sum_ext > SUM_MAX);
    assign sum_next = sat ? SUM_ALL : sum_ext[SUM_WIDTH-1:0];
    assign ovf_next = ovf_reg || sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            ovf_reg   <= 1'b0;
            h_tag_reg <= '0;
        end
        else if (advance)
        begin
            h_tag_reg.valid <= b_valid_reg && b_last_reg;
            h_tag_reg.ovf   <= ovf_next;
            if (b_valid_reg)
            begin
                if (b_last_reg)
                begin
                    sum_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    ovf_reg <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h_sum_reg <= sum_next;
        end
    end

    // Row of root cells, one root bit each, top bit first
    assign tag_chain[0] = h_tag_reg;
    assign x_chain[0]   = X_W'(h_sum_reg);
    assign rem_chain[0] = '0;
    assign q_chain[0]   = '0;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        if (i < ROOT_W - 1)
        begin : g_mid
            eds_sqrt_cell #(
                .ROOT_W (ROOT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (advance),
                .tag_in  (tag_chain[i]),
                .x_in    (x_chain[i]),
                .rem_in  (rem_chain[i]),
                .q_in    (q_chain[i]),
                .tag_out (tag_chain[i+1]),
                .x_out   (x_chain[i+1]),
                .rem_out (rem_chain[i+1]),
                .q_out   (q_chain[i+1])
            );
        end
        else
        begin : g_end
            eds_sqrt_cell #(
                .ROOT_W (ROOT_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (advance),
                .tag_in  (tag_chain[i]),
                .x_in    (x_chain[i]),
                .rem_in  (rem_chain[i]),
                .q_in    (q_chain[i]),
                .tag_out (tag_chain[i+1]),
                .x_out   (),
                .rem_out (),
                .q_out   (q_chain[i+1])
            );
        end
    end

    // Result transaction, distance clipped to its field
    assign q_wide   = QX_W'(q_chain[ROOT_W]);
    assign m_tvalid = tag_chain[ROOT_W].valid;
    assign m_tdata  = (q_wide > QX_W'(DIST_MAX)) ? DIST_MAX : q_wide[DIST_W-1:0];
    assign m_tuser  = tag_chain[ROOT_W].ovf;

    // Checks
    `EDS_ASSERT_NEXT(a_sum_clear, b_valid_reg && b_last_reg && advance, sum_reg == '0 && !ovf_reg)
    `EDS_ASSERT_IMPL(a_ovf_sum_max, ovf_reg, sum_reg == SUM_ALL)
    `EDS_ASSERT_IMPL(a_ovf_dist, m_tvalid && m_tuser[0], m_tdata != '0)
    `EDS_ASSERT_NEXT(a_hold_handoff, !advance && h_tag_reg.valid, h_tag_reg.valid)

endmodule

`default_nettype wire

@@ design/eds_sqrt_cell.sv @@
// One digit step of the restoring integer square root, registered.
`default_nettype none

module eds_sqrt_cell
    import eds_pkg::*;
#(
    parameter int ROOT_W = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire eds_tag_t              tag_in,
    input  wire logic [2*ROOT_W-1:0]   x_in,
    input  wire logic [ROOT_W:0]       rem_in,
    input  wire logic [ROOT_W-1:0]     q_in,
    output eds_tag_t                   tag_out,
    output logic [2*ROOT_W-1:0]        x_out,
    output logic [ROOT_W:0]            rem_out,
    output logic [ROOT_W-1:0]          q_out
);

    localparam int X_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int TRY_W = ROOT_W + 3;

    logic [TRY_W-1:0]  rem_try;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  rem_sub;
    logic              take;
    logic [REM_W-1:0]  rem_next;
    logic [X_W-1:0]    x_next;
    logic [ROOT_W-1:0] q_next;

    eds_tag_t          tag_reg;
    logic [X_W-1:0]    x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] q_reg;

    // Bring down the next two radicand bits and try (4q + 1)
    assign rem_try  = {rem_in, x_in[X_W-1 -: 2]};
    assign trial    = {1'b0, q_in, 2'b01};
    assign take     = (rem_try >= trial);
    assign rem_sub  = rem_try - trial;
    assign rem_next = take ? rem_sub[REM_W-1:0] : rem_try[REM_W-1:0];
    assign x_next   = {x_in[X_W-3:0], 2'b00};
    assign q_next   = {q_in[ROOT_W-2:0], take};

    // Control tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign tag_out = tag_reg;
    assign x_out   = x_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the euclidean distance stream block.
module tb_top;
    import eds_pkg::*;

    localparam int          ELEM_W    = 16;
    localparam int          SUM_W     = 48;
    localparam int          IN_W      = ((2 * ELEM_W + 7) / 8) * 8;
    localparam int          PIPE_LAT  = 3 + (SUM_W + 1) / 2;
    localparam logic [63:0] SUM_CEIL  = 64'h0000_FFFF_FFFF_FFFF;
    localparam int          RAND_PAIRS = 528;
    localparam int          NUM_ROWS  = 22;

    // One directed row; the distance is typed in only where it is obvious
    typedef struct {
        int a;
        int b;
        bit last;
        bit typed;
        int dist_val;
        bit ovf;
    } pair_row_t;

    typedef struct {
        logic [DIST_W-1:0] dist_val;
        logic              ovf;
    } dist_result_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // elem_a, elem_b
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // distance
    logic [DIST_W-1:0]     m_tdata;
    // sum_overflow
    logic [0:0]            m_tuser;

    // Predictor state: running sum of squares and sticky saturation flag
    logic [63:0]           sq_sum   = '0;
    bit                    sat_seen = 1'b0;

    dist_result_t          pending_distances[$];
    int                    fail_count = 0;
    bit                    no_idle    = 1'b0;
    pair_row_t             directed_rows [0:NUM_ROWS-1];

    euclidean_distance_stream #(
        .ELEM_WIDTH (ELEM_W),
        .SUM_WIDTH  (SUM_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Receiver backpressure, off during the no-idle stretch
    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 36);
    end

    // Floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = x;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Accumulate one pair; on the last pair produce the distance and clear
    task automatic predict_distance(input logic signed [ELEM_W-1:0] a,
                                    input logic signed [ELEM_W-1:0] b,
                                    input bit last,
                                    output bit has_result,
                                    output dist_result_t res);
        logic signed [ELEM_W+1:0] diff;
        logic [ELEM_W:0]          mag;
        logic [63:0]              sq;
        logic [63:0]              root;
        diff = a - b;
        mag  = (diff < 0) ? -diff : diff;
        sq   = mag * mag;
        if (sq > SUM_CEIL - sq_sum)
        begin
            sq_sum   = SUM_CEIL;
            sat_seen = 1'b1;
        end
        else
            sq_sum = sq_sum + sq;
        has_result   = last;
        res.dist_val = '0;
        res.ovf      = 1'b0;
        if (last)
        begin
            root = floor_sqrt(sq_sum);
            if (root > 64'(DIST_MAX))
                root = 64'(DIST_MAX);
            res.dist_val = root[DIST_W-1:0];
            res.ovf      = sat_seen;
            sq_sum       = '0;
            sat_seen     = 1'b0;
        end
    endtask

    // Offer one pair, wait for the transaction, then record what it should give
    task automatic drive_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                              input bit last, input bit typed,
                              input logic [DIST_W-1:0] typed_dist, input bit typed_ovf);
        bit           has_result;
        dist_result_t res;
        while (!no_idle && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_distance(a, b, last, has_result, res);
        if (typed)
        begin
            res.dist_val = typed_dist;
            res.ovf      = typed_ovf;
        end
        if (has_result)
            pending_distances.push_back(res);
    endtask

    // Hold the sender until every expected distance is out, then let the pipe settle
    task automatic wait_results_out();
        s_tvalid <= 1'b0;
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // Element values: extremes, small values near zero, or anything
    function automatic logic [ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        dist_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_distances.size() == 0)
            begin
                $error("unexpected result: distance=%0d sum_overflow=%0d",
                       m_tdata, m_tuser[0]);
                fail_count++;
            end
            else
            begin
                want = pending_distances.pop_front();
                if (m_tdata !== want.dist_val)
                begin
                    $error("distance: expected %0d, actual %0d", want.dist_val, m_tdata);
                    fail_count++;
                end
                if (m_tuser[0] !== want.ovf)
                begin
                    $error("sum_overflow: expected %0d, actual %0d", want.ovf, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int  sent;
        int  vec_len;
        bit  paused;
        sent   = 0;
        paused = 1'b0;

        directed_rows = '{
            '{0,      0,      1'b1, 1'b1, 0,     1'b0},   // zero after reset
            '{32767,  -32768, 1'b1, 1'b1, 65535, 1'b0},   // widest difference
            '{-32768, 32767,  1'b1, 1'b1, 65535, 1'b0},
            '{32767,  32767,  1'b1, 1'b1, 0,     1'b0},
            '{-32768, -32768, 1'b1, 1'b1, 0,     1'b0},
            '{256,    0,      1'b1, 1'b1, 256,   1'b0},   // 1.0 in Q8.8
            '{-1,     0,      1'b1, 1'b1, 1,     1'b0},
            '{1,      0,      1'b0, 1'b0, 0,     1'b0},   // sum 2, root truncated
            '{0,      -1,     1'b1, 1'b1, 1,     1'b0},
            '{3,      0,      1'b0, 1'b0, 0,     1'b0},
            '{0,      4,      1'b1, 1'b1, 5,     1'b0},
            '{2,      -2,     1'b0, 1'b0, 0,     1'b0},   // sum 24, root truncated
            '{2,      0,      1'b0, 1'b0, 0,     1'b0},
            '{0,      2,      1'b1, 1'b1, 4,     1'b0},
            '{21845,  -21846, 1'b0, 1'b0, 0,     1'b0},   // alternating bit patterns
            '{-21846, 21845,  1'b0, 1'b0, 0,     1'b0},
            '{100,    -200,   1'b0, 1'b0, 0,     1'b0},
            '{-5000,  7000,   1'b1, 1'b0, 0,     1'b0},
            '{12345,  -23456, 1'b0, 1'b0, 0,     1'b0},
            '{-32768, 32767,  1'b0, 1'b0, 0,     1'b0},
            '{32767,  -32768, 1'b1, 1'b0, 0,     1'b0},
            '{-17,    -300,   1'b1, 1'b0, 0,     1'b0}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        foreach (directed_rows[i])
            drive_pair(16'(directed_rows[i].a), 16'(directed_rows[i].b),
                       directed_rows[i].last, directed_rows[i].typed,
                       24'(directed_rows[i].dist_val), directed_rows[i].ovf);
        wait_results_out();

        // Random vectors, mostly short; the first stretch runs with no idling
        no_idle = 1'b1;
        while (sent < RAND_PAIRS)
        begin
            if (no_idle && sent >= RAND_PAIRS / 4)
                no_idle = 1'b0;
            if (!paused && sent >= RAND_PAIRS / 2)
            begin
                wait_results_out();
                paused = 1'b1;
            end
            vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < vec_len; k++)
            begin
                drive_pair(pick_elem(), pick_elem(), k == vec_len - 1, 1'b0, '0, 1'b0);
                sent++;
            end
        end

        wait_results_out();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(600_000 * 12);
        $display("TEST FAILED");
        $finish;
    end

endmodule
